// ===== rtl/core/mfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfsd_pkg - shared types and constants for the marker framed sum deframer
// frame status codes, result item layout and payload length limit
// ----------------------------------------------------------------------------
package mfsd_pkg;

  localparam int MAX_FRAME = 256;

  // longest payload that still leaves room for start, checksum and end
  localparam int LEN_LIMIT_INT = (MAX_FRAME - 3 < 253) ? (MAX_FRAME - 3) : 253;
  localparam logic [7:0] LEN_LIMIT = 8'(LEN_LIMIT_INT);

  typedef enum logic [2:0] {
    ST_BUSY    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_BAD_END = 3'd2,
    ST_BAD_SUM = 3'd3,
    ST_DISCARD = 3'd4
  } frame_status_t;

  typedef enum logic [1:0] {
    REG_START_MARKER   = 2'd0,
    REG_END_MARKER     = 2'd1,
    REG_PAYLOAD_LENGTH = 2'd2
  } reg_index_t;

  typedef struct packed {
    frame_status_t frame_status;
    logic          frame_done;
    logic [7:0]    payload_index;
    logic          is_payload;
    logic [7:0]    data_byte;
  } result_t;

endpackage

// ===== rtl/core/marker_framed_sum_deframer.sv =====
// ----------------------------------------------------------------------------
// marker_framed_sum_deframer - start/end marker frame receiver, 8-bit sum check
// throughput: one byte per cycle while the skid entry is empty, as set by
// the position counter and sum adder; each result item goes into the output
// register, or into the skid entry that holds one extra result on a stall
// reset (rst, synchronous): hunting, sums, config, valid flags cleared to zero
// ----------------------------------------------------------------------------
module marker_framed_sum_deframer (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [15:8] payload_index
  output logic [3:0]  m_axis_tuser,   // [0] is_payload, [3:1] frame_status
  output logic        m_axis_tlast,   // frame_done
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import mfsd_pkg::*;

  logic [7:0] start_marker;
  logic [7:0] end_marker;
  logic [7:0] payload_length;

  logic [7:0] frame_position;
  logic [7:0] running_sum;
  logic [7:0] received_checksum;
  logic [7:0] frame_position_next;
  logic [7:0] running_sum_next;
  logic [7:0] received_checksum_next;

  result_t    res;
  result_t    out_item;
  result_t    skid_item;
  logic       skid_valid;
  logic       in_accept;
  logic       out_free;
  logic [8:0] sum_slot;
  logic [7:0] end_sum;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // register writes, out-of-range payload length saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker   <= '0;
      end_marker     <= '0;
      payload_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_START_MARKER:   start_marker <= cfg_data;
        REG_END_MARKER:     end_marker   <= cfg_data;
        REG_PAYLOAD_LENGTH: payload_length <= (cfg_data > LEN_LIMIT) ? LEN_LIMIT : cfg_data;
        default: ;
      endcase
    end
  end

  assign sum_slot = {1'b0, payload_length} + 9'd1;
  assign end_sum  = running_sum + s_axis_tdata;

  always_comb begin
    frame_position_next    = frame_position;
    running_sum_next       = running_sum;
    received_checksum_next = received_checksum;
    res.data_byte          = s_axis_tdata;
    res.is_payload         = 1'b0;
    res.payload_index      = '0;
    res.frame_done         = 1'b0;
    res.frame_status       = ST_BUSY;
    if (frame_position == '0) begin
      if (s_axis_tdata == start_marker) begin
        running_sum_next    = s_axis_tdata;
        frame_position_next = 8'd1;
      end else begin
        res.frame_status = ST_DISCARD;
      end
    end else if (frame_position <= payload_length) begin
      res.is_payload      = 1'b1;
      res.payload_index   = frame_position - 8'd1;
      running_sum_next    = end_sum;
      frame_position_next = frame_position + 8'd1;
    end else if ({1'b0, frame_position} == sum_slot) begin
      received_checksum_next = s_axis_tdata;
      frame_position_next    = frame_position + 8'd1;
    end else begin
      res.frame_done = 1'b1;
      if (s_axis_tdata != end_marker) begin
        res.frame_status = ST_BAD_END;
      end else if (end_sum == received_checksum) begin
        res.frame_status = ST_GOOD;
      end else begin
        res.frame_status = ST_BAD_SUM;
      end
      frame_position_next = '0;
      running_sum_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= '0;
      running_sum       <= '0;
      received_checksum <= '0;
    end else if (in_accept) begin
      frame_position    <= frame_position_next;
      running_sum       <= running_sum_next;
      received_checksum <= received_checksum_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_item      <= skid_item;
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else if (in_accept) begin
        out_item      <= res;
        m_axis_tvalid <= 1'b1;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end else if (in_accept) begin
      skid_item  <= res;
      skid_valid <= 1'b1;
    end
  end

  assign m_axis_tdata = {out_item.payload_index, out_item.data_byte};
  assign m_axis_tuser = {out_item.frame_status, out_item.is_payload};
  assign m_axis_tlast = out_item.frame_done;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid entry held while output register empty");

  a_done_has_verdict: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tuser[3:1] == ST_GOOD || m_axis_tuser[3:1] == ST_BAD_END ||
       m_axis_tuser[3:1] == ST_BAD_SUM))
    else $error("frame end item without a final status");

  a_payload_in_progress: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tuser[3:1] == ST_BUSY && !m_axis_tlast))
    else $error("payload item carries a final status");

  a_discard_keeps_hunting: assert property (@(posedge clk) disable iff (rst)
    (in_accept && frame_position == '0 && s_axis_tdata != start_marker)
      |=> frame_position == '0)
    else $error("left hunting on a non-start byte");

endmodule

// ===== tb/sv/tb_marker_framed_sum_deframer.sv =====
// ----------------------------------------------------------------------------
// tb_marker_framed_sum_deframer - self-checking bench for the frame deframer
// drives byte streams of good, damaged and cut frames plus noise, with bursty
// input and a stalling output, and checks every result item against its own
// tracker of frame position, running sum and register state
// ----------------------------------------------------------------------------
module tb_marker_framed_sum_deframer;
  import mfsd_pkg::*;

  localparam int         ITEM_TARGET  = 1150;
  localparam int         QUIET_LIMIT  = 2000;
  localparam logic [1:0] REG_UNUSED   = 2'd3;

  localparam int KIND_GOOD    = 0;
  localparam int KIND_BAD_END = 1;
  localparam int KIND_BAD_SUM = 2;
  localparam int KIND_CUT     = 3;

  class frame_tracker;
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] payload_length;
    logic [7:0] position;
    logic [7:0] running_sum;
    logic [7:0] rx_checksum;
    result_t    pending_items[$];
    int         errors;

    function new();
      start_marker   = '0;
      end_marker     = '0;
      payload_length = '0;
      position       = '0;
      running_sum    = '0;
      rx_checksum    = '0;
      errors         = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_START_MARKER:   start_marker = val;
        REG_END_MARKER:     end_marker = val;
        REG_PAYLOAD_LENGTH: payload_length = (val > LEN_LIMIT) ? LEN_LIMIT : val;
        default: ;
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      result_t     r;
      logic [7:0]  total;
      int unsigned pos;
      int unsigned len;
      r              = '0;
      r.data_byte    = b;
      r.frame_status = ST_BUSY;
      pos            = position;
      len            = payload_length;
      if (pos == 0) begin
        if (b == start_marker) begin
          running_sum = b;
          position    = 8'd1;
        end else begin
          r.frame_status = ST_DISCARD;
        end
      end else if (pos <= len) begin
        r.is_payload    = 1'b1;
        r.payload_index = 8'(pos - 1);
        running_sum     = running_sum + b;
        position        = position + 8'd1;
      end else if (pos == len + 1) begin
        rx_checksum = b;
        position    = position + 8'd1;
      end else begin
        // end slot, also reached when the length shrank under a running frame
        r.frame_done = 1'b1;
        total        = running_sum + b;
        if (b != end_marker) begin
          r.frame_status = ST_BAD_END;
        end else if (total == rx_checksum) begin
          r.frame_status = ST_GOOD;
        end else begin
          r.frame_status = ST_BAD_SUM;
        end
        position    = '0;
        running_sum = '0;
      end
      pending_items.push_back(r);
    endfunction

    function void mismatch(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    function void check_item(result_t got);
      result_t want;
      if (pending_items.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_items.pop_front();
      if (got.data_byte != want.data_byte)
        mismatch("data_byte", want.data_byte, got.data_byte);
      if (got.is_payload != want.is_payload)
        mismatch("is_payload", want.is_payload, got.is_payload);
      if (got.payload_index != want.payload_index)
        mismatch("payload_index", want.payload_index, got.payload_index);
      if (got.frame_done != want.frame_done)
        mismatch("frame_done", want.frame_done, got.frame_done);
      if (got.frame_status !== want.frame_status)
        mismatch("frame_status", want.frame_status, got.frame_status);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  frame_tracker tracker;
  result_t      seen_item;
  int           items_sent;
  int           burst_left;
  bit           steady;
  int           quiet_cycles;
  int           stall_step;
  logic [15:0]  stall_mask;

  marker_framed_sum_deframer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // output side: check accepted items, stall on a rotating random mask
  initial begin
    stall_step = 0;
    stall_mask = 16'hffff;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_item.data_byte     = m_axis_tdata[7:0];
      seen_item.payload_index = m_axis_tdata[15:8];
      seen_item.is_payload    = m_axis_tuser[0];
      seen_item.frame_status  = frame_status_t'(m_axis_tuser[3:1]);
      seen_item.frame_done    = m_axis_tlast;
      tracker.check_item(seen_item);
    end
    m_axis_tready <= stall_mask[stall_step[3:0]];
    stall_step = stall_step + 1;
    if (stall_step == 48) begin
      stall_step = 0;
      // some windows never stall at all
      stall_mask = ($urandom_range(3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!steady && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_byte(b);
    items_sent++;
    if (burst_left > 0) burst_left--;
  endtask

  // stop input and let every outstanding result come out
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_items.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_frame(input int kind);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    logic [7:0] pay;
    int         keep;
    sum = tracker.start_marker + tracker.end_marker;
    bytes_q.push_back(tracker.start_marker);
    for (int i = 0; i < int'(tracker.payload_length); i++) begin
      pay = 8'($urandom);
      sum = sum + pay;
      bytes_q.push_back(pay);
    end
    bytes_q.push_back((kind == KIND_BAD_SUM) ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    bytes_q.push_back((kind == KIND_BAD_END) ?
                      (tracker.end_marker ^ 8'($urandom_range(1, 255))) : tracker.end_marker);
    keep = (kind == KIND_CUT) ? $urandom_range(1, bytes_q.size() - 1) : bytes_q.size();
    for (int i = 0; i < keep; i++) push_byte(bytes_q[i]);
  endtask

  function automatic logic [7:0] pick_marker();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int          pick;
    int          actions;
    logic [7:0]  cks;
    bit          first_phase;
    tracker       = new();
    items_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    quiet_cycles  = 0;
    first_phase   = 1'b1;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset config: zero markers, empty payload
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'h00);
    drain_stream();

    set_reg(REG_START_MARKER, 8'ha5);
    set_reg(REG_END_MARKER, 8'h5a);
    set_reg(REG_PAYLOAD_LENGTH, 8'd2);
    set_reg(REG_UNUSED, 8'h77);
    push_byte(8'h3c);
    cks = 8'ha5 + 8'h5a + 8'h00 + 8'hff;
    push_byte(8'ha5);
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(cks);
    push_byte(8'h5a);
    cks = 8'ha5 + 8'h5a + 8'h01 + 8'h02;
    push_byte(8'ha5);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(cks);
    push_byte(8'h11);
    push_byte(8'ha5);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(cks ^ 8'h80);
    push_byte(8'h5a);
    // bad end byte equal to the start marker must not reopen a frame
    push_byte(8'ha5);
    push_byte(8'h01);
    push_byte(8'h02);
    push_byte(cks);
    push_byte(8'ha5);
    push_byte(8'h7e);
    drain_stream();

    // oversized length saturates, then shrinks under a running frame
    set_reg(REG_START_MARKER, 8'hff);
    set_reg(REG_END_MARKER, 8'h00);
    set_reg(REG_PAYLOAD_LENGTH, 8'hff);
    push_byte(8'hff);
    push_byte(8'h11);
    push_byte(8'h22);
    push_byte(8'h33);
    drain_stream();
    set_reg(REG_PAYLOAD_LENGTH, 8'd1);
    push_byte(8'h00);
    push_byte(8'hff);
    drain_stream();

    while (items_sent < ITEM_TARGET) begin
      if (first_phase || $urandom_range(2) != 0) set_reg(REG_START_MARKER, pick_marker());
      if (first_phase || $urandom_range(2) != 0) set_reg(REG_END_MARKER, pick_marker());
      if (first_phase || $urandom_range(2) != 0) begin
        pick = $urandom_range(99);
        if (pick < 6)       set_reg(REG_PAYLOAD_LENGTH, 8'($urandom_range(240, 255)));
        else if (pick < 14) set_reg(REG_PAYLOAD_LENGTH, 8'd0);
        else                set_reg(REG_PAYLOAD_LENGTH, 8'($urandom_range(1, 10)));
      end
      if ($urandom_range(9) == 0) set_reg(REG_UNUSED, 8'($urandom));
      first_phase = 1'b0;
      steady      = ($urandom_range(3) == 0);
      actions     = (tracker.payload_length > 20) ? 1 : $urandom_range(4, 14);
      repeat (actions) begin
        pick = $urandom_range(99);
        if (pick < 55)      send_frame(KIND_GOOD);
        else if (pick < 67) send_frame(KIND_BAD_END);
        else if (pick < 79) send_frame(KIND_BAD_SUM);
        else if (pick < 89) send_frame(KIND_CUT);
        else repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
      end
      drain_stream();
    end

    repeat (5) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_items.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
